// File: src/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
`default_nettype none
package bpa_pkg;

  localparam int ORDER_COUNT_DEF = 11;
  localparam int PAGE_DEPTH_DEF  = 16384;
  localparam int PAGE_BYTES_DEF  = 4096;

  localparam logic [15:0] NIL_LINK        = 16'hFFFF;
  localparam logic [31:0] REGION_BASE_RST = 32'h0100_0000;
  localparam logic [14:0] SPAN_RST        = 15'd16384;

  // Configuration register indexes.
  localparam logic REG_REGION_BASE = 1'b0;
  localparam logic REG_SPAN        = 1'b1;

  typedef enum logic [2:0] {
    K_RESERVED   = 3'd0,
    K_FREE_HEAD  = 3'd1,
    K_FREE_TAIL  = 3'd2,
    K_ALLOC_HEAD = 3'd3,
    K_ALLOC_TAIL = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ACT_ALLOC     = 3'd0,
    ACT_FREE_CHK  = 3'd1,
    ACT_FREE_ANY  = 3'd2,
    ACT_RELEASE   = 3'd3,
    ACT_SET_READY = 3'd4,
    ACT_CLEAR     = 3'd5,
    ACT_NOP6      = 3'd6,
    ACT_NOP7      = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_BAD_ORDER = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_BAD_ADDR  = 3'd4,
    ST_NOT_HEAD  = 3'd5,
    ST_MISMATCH  = 3'd6,
    ST_REJECTED  = 3'd7
  } status_t;

  // One page descriptor as held in the descriptor memory.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  order;
    logic [15:0] next;
    logic [15:0] prev;
  } page_desc_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_A_SCAN, S_A_SPLIT, S_A_TAIL, S_F_CHK, S_F_TAIL,
    S_R_CHK, S_M0, S_M1, S_M2, S_MPUSH, S_UL0, S_UL1, S_UL2, S_UL3, S_UL4,
    S_PS0, S_PS1, S_CLR, S_QUERY, S_DONE
  } fsm_t;

endpackage
`default_nettype wire

// File: src/buddy_page_allocator_core.sv
// Buddy page allocator: descriptor memory, free lists and the sequencer that walks them.
//
//  Channel | Direction | Signals                         | Contents
//  s_      | in        | tvalid tready tdata[39:0]       | action, block_order, byte_address
//  m_      | out       | tvalid tready tdata[87:0]       | status .. address_is_managed
//  apb     | in/out    | psel penable pwrite paddr ...   | region_base, span_page_count
//
// An item passes through accept, dispatch, query and result at the least. Allocate adds the
// scan over the orders, an unlink, the splits, then a write of each tail page; free adds a
// write of each tail page and the merge levels. The descriptor memory has one read port and
// one write port.
// After reset, and on the clear action, a sweep rewrites every descriptor with no item
// accepted. A finished item waits in the output register meanwhile.
`default_nettype none
module buddy_page_allocator_core import bpa_pkg::*; #(
  parameter int ORDER_COUNT = ORDER_COUNT_DEF,
  parameter int PAGE_DEPTH  = PAGE_DEPTH_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // action[2:0], block_order[6:3], byte_address[38:7], zero[39]
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[2:0], block_address[34:3], result_order[38:35], free_page_total[53:39],
  // managed_page_total[68:54], free_blocks_at_order[83:69], address_is_managed[84], zero[87:85]
  output logic [87:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PW  = $clog2(PAGE_DEPTH);
  localparam int PBW = $clog2(PAGE_BYTES);
  localparam int OIW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
  localparam int CW  = ORDER_COUNT + 1;
  localparam page_desc_t DESC_RST = '{kind: K_RESERVED, order: 4'd0, next: NIL_LINK,
                                      prev: NIL_LINK};

  // Configuration registers.
  logic [31:0] region_base;
  logic [14:0] span_len;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SPAN) ? {17'd0, span_len} : region_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= REGION_BASE_RST;
      span_len    <= SPAN_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_REGION_BASE) region_base <= pwdata;
      else span_len <= pwdata[14:0];
    end
  end

  // Descriptor memory with registered read data.
  page_desc_t desc_mem [PAGE_DEPTH];
  page_desc_t rd_q;
  logic       mem_we;
  logic [PW-1:0] mem_wa, mem_ra;
  page_desc_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) desc_mem[mem_wa] <= mem_wd;
    rd_q <= desc_mem[mem_ra];
  end

  // Sequencer registers.
  fsm_t state, state_next, ret, ret_next;
  logic boot, boot_next;
  logic [2:0] act, act_next;
  logic [3:0] ordin, ordin_next;
  logic [31:0] addr, addr_next;
  logic [3:0] k, k_next;
  logic [PW-1:0] idx, idx_next;
  logic [2:0] st, st_next;
  logic [3:0] res_ord, res_ord_next;
  logic [31:0] baddr, baddr_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [PW-1:0] u_idx, u_idx_next, p_idx, p_idx_next, m_idx, m_idx_next, bud, bud_next;
  logic [3:0] u_ord, u_ord_next, p_ord, p_ord_next, m_ord, m_ord_next;
  logic [15:0] ln, ln_next, lp, lp_next;
  logic [PW-1:0] clr, clr_next;
  logic [15:0] head [ORDER_COUNT];
  logic [15:0] head_next [ORDER_COUNT];
  logic [14:0] blk_cnt [ORDER_COUNT];
  logic [14:0] blk_cnt_next [ORDER_COUNT];
  logic [14:0] free_pages, free_pages_next, pool_pages, pool_pages_next;
  logic ready_flag, ready_flag_next;
  logic out_valid, out_valid_next;
  logic [87:0] out_data, out_data_next;

  // Address decode, shared by free, release and the managed query.
  logic [31:0] span_lim, dec_off, dec_pg, tmp_pg;
  logic dec_ok, q_ok;
  logic [PW-1:0] page_ix;
  logic [14:0] fblocks;
  logic mbit;

  always_comb begin
    span_lim = (32'(span_len) > 32'(PAGE_DEPTH)) ? 32'(PAGE_DEPTH) : 32'(span_len);
    dec_off  = addr - region_base;
    dec_pg   = dec_off >> PBW;
    dec_ok   = (addr >= region_base) && (dec_off[PBW-1:0] == '0) && (dec_pg < span_lim);
    q_ok     = ready_flag && (addr >= region_base) && (dec_pg < span_lim);
    page_ix  = dec_pg[PW-1:0];
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Next state and datapath of the sequencer.
  always_comb begin
    state_next = state; ret_next = ret; boot_next = boot;
    act_next = act; ordin_next = ordin; addr_next = addr; k_next = k; idx_next = idx;
    st_next = st; res_ord_next = res_ord; baddr_next = baddr; cnt_next = cnt;
    u_idx_next = u_idx; p_idx_next = p_idx; m_idx_next = m_idx; bud_next = bud;
    u_ord_next = u_ord; p_ord_next = p_ord; m_ord_next = m_ord;
    ln_next = ln; lp_next = lp; clr_next = clr;
    head_next = head; blk_cnt_next = blk_cnt;
    free_pages_next = free_pages; pool_pages_next = pool_pages;
    ready_flag_next = ready_flag;
    out_valid_next = out_valid && !m_tready;
    out_data_next = out_data;
    mem_we = 1'b0; mem_wa = '0; mem_wd = DESC_RST; mem_ra = '0;
    tmp_pg = '0;
    fblocks = '0;
    mbit = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          act_next = s_tdata[2:0]; ordin_next = s_tdata[6:3]; addr_next = s_tdata[38:7];
          st_next = ST_OK; res_ord_next = '0; baddr_next = '0;
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        mem_ra = page_ix;
        state_next = S_QUERY;
        unique case (act)
          ACT_ALLOC: begin
            if (!ready_flag) st_next = ST_NOT_READY;
            else if (32'(ordin) >= 32'(ORDER_COUNT)) st_next = ST_BAD_ORDER;
            else begin
              k_next = ordin;
              state_next = S_A_SCAN;
            end
          end
          ACT_FREE_CHK, ACT_FREE_ANY: begin
            if (act == ACT_FREE_CHK && 32'(ordin) >= 32'(ORDER_COUNT)) st_next = ST_BAD_ORDER;
            else if (!ready_flag) st_next = ST_NOT_READY;
            else if (!dec_ok) st_next = ST_BAD_ADDR;
            else begin
              idx_next = page_ix;
              state_next = S_F_CHK;
            end
          end
          ACT_RELEASE: begin
            if (!dec_ok) st_next = ST_BAD_ADDR;
            else begin
              idx_next = page_ix;
              state_next = S_R_CHK;
            end
          end
          ACT_SET_READY: ready_flag_next = 1'b1;
          ACT_CLEAR: begin
            for (int i = 0; i < ORDER_COUNT; i++) begin
              head_next[i] = NIL_LINK;
              blk_cnt_next[i] = '0;
            end
            free_pages_next = '0; pool_pages_next = '0; ready_flag_next = 1'b0;
            clr_next = '0;
            state_next = S_CLR;
          end
          default: ;
        endcase
      end

      // Allocate: find the smallest nonempty order not below the requested one.
      S_A_SCAN: begin
        if (32'(k) >= 32'(ORDER_COUNT)) begin
          st_next = ST_NO_MEM;
          state_next = S_QUERY;
        end else if (32'(head[k[OIW-1:0]]) >= 32'(PAGE_DEPTH)) begin
          k_next = k + 4'd1;
        end else begin
          idx_next = head[k[OIW-1:0]][PW-1:0];
          u_idx_next = head[k[OIW-1:0]][PW-1:0];
          u_ord_next = k;
          ret_next = S_A_SPLIT;
          state_next = S_UL0;
        end
      end

      // Split the block down, pushing each upper half, then mark the head.
      S_A_SPLIT: begin
        if (k > ordin) begin
          k_next = k - 4'd1;
          tmp_pg = 32'(idx) + (32'd1 << (k - 4'd1));
          if (tmp_pg < 32'(PAGE_DEPTH)) begin
            p_idx_next = tmp_pg[PW-1:0];
            p_ord_next = k - 4'd1;
            ret_next = S_A_SPLIT;
            state_next = S_PS0;
          end
        end else begin
          mem_we = 1'b1; mem_wa = idx;
          mem_wd = '{kind: K_ALLOC_HEAD, order: ordin, next: NIL_LINK, prev: NIL_LINK};
          cnt_next = CW'(1);
          state_next = S_A_TAIL;
        end
      end

      S_A_TAIL: begin
        if (cnt < (CW'(1) << ordin)) begin
          tmp_pg = 32'(idx) + 32'(cnt);
          if (tmp_pg < 32'(PAGE_DEPTH)) begin
            mem_we = 1'b1; mem_wa = tmp_pg[PW-1:0];
            mem_wd = '{kind: K_ALLOC_TAIL, order: 4'd0, next: NIL_LINK, prev: NIL_LINK};
          end
          cnt_next = cnt + CW'(1);
        end else begin
          free_pages_next = (32'(free_pages) >= (32'd1 << ordin)) ?
                            free_pages - 15'((32'd1 << ordin)) : '0;
          baddr_next = region_base + (32'(idx) << PBW);
          res_ord_next = ordin;
          state_next = S_QUERY;
        end
      end

      // Free: check the head, then mark tails free and merge.
      S_F_CHK: begin
        if (rd_q.kind != K_ALLOC_HEAD) begin
          st_next = ST_NOT_HEAD;
          state_next = S_QUERY;
        end else if (act == ACT_FREE_CHK && rd_q.order != ordin) begin
          st_next = ST_MISMATCH;
          state_next = S_QUERY;
        end else begin
          m_idx_next = idx;
          m_ord_next = rd_q.order;
          res_ord_next = rd_q.order;
          free_pages_next = free_pages + 15'((32'd1 << rd_q.order));
          cnt_next = CW'(1);
          state_next = S_F_TAIL;
        end
      end

      S_F_TAIL: begin
        if (cnt < (CW'(1) << m_ord)) begin
          tmp_pg = 32'(idx) + 32'(cnt);
          if (tmp_pg < 32'(PAGE_DEPTH)) begin
            mem_we = 1'b1; mem_wa = tmp_pg[PW-1:0];
            mem_wd = '{kind: K_FREE_TAIL, order: 4'd0, next: NIL_LINK, prev: NIL_LINK};
          end
          cnt_next = cnt + CW'(1);
        end else begin
          state_next = S_M0;
        end
      end

      // Release: only a reserved page joins the pool.
      S_R_CHK: begin
        if (rd_q.kind != K_RESERVED) begin
          st_next = ST_REJECTED;
          state_next = S_QUERY;
        end else begin
          pool_pages_next = pool_pages + 15'd1;
          free_pages_next = free_pages + 15'd1;
          m_idx_next = idx;
          m_ord_next = '0;
          state_next = S_M0;
        end
      end

      // Merge: look at the buddy of the current block.
      S_M0: begin
        tmp_pg = 32'(m_idx) ^ (32'd1 << m_ord);
        if ((32'(m_ord) + 32'd1 < 32'(ORDER_COUNT)) && (tmp_pg < span_lim)) begin
          bud_next = tmp_pg[PW-1:0];
          mem_ra = tmp_pg[PW-1:0];
          state_next = S_M1;
        end else begin
          state_next = S_MPUSH;
        end
      end

      S_M1: begin
        if (rd_q.kind != K_FREE_HEAD || rd_q.order != m_ord) begin
          state_next = S_MPUSH;
        end else begin
          u_idx_next = bud;
          u_ord_next = m_ord;
          ret_next = S_M2;
          state_next = S_UL0;
        end
      end

      S_M2: begin
        mem_we = 1'b1;
        mem_wd = '{kind: K_FREE_TAIL, order: 4'd0, next: NIL_LINK, prev: NIL_LINK};
        if (m_idx < bud) begin
          mem_wa = bud;
        end else begin
          mem_wa = m_idx;
          m_idx_next = bud;
        end
        m_ord_next = m_ord + 4'd1;
        state_next = S_M0;
      end

      S_MPUSH: begin
        if (act == ACT_RELEASE) res_ord_next = m_ord;
        p_idx_next = m_idx;
        p_ord_next = m_ord;
        ret_next = S_QUERY;
        state_next = S_PS0;
      end

      // Unlink a block from its free list.
      S_UL0: begin
        mem_ra = u_idx;
        state_next = S_UL1;
      end

      S_UL1: begin
        lp_next = rd_q.prev;
        ln_next = rd_q.next;
        mem_we = 1'b1; mem_wa = u_idx;
        mem_wd = '{kind: rd_q.kind, order: rd_q.order, next: NIL_LINK, prev: NIL_LINK};
        if (blk_cnt[u_ord[OIW-1:0]] != '0)
          blk_cnt_next[u_ord[OIW-1:0]] = blk_cnt[u_ord[OIW-1:0]] - 15'd1;
        if (32'(rd_q.prev) < 32'(PAGE_DEPTH)) begin
          mem_ra = rd_q.prev[PW-1:0];
          state_next = S_UL2;
        end else begin
          head_next[u_ord[OIW-1:0]] = rd_q.next;
          state_next = S_UL3;
        end
      end

      S_UL2: begin
        mem_we = 1'b1; mem_wa = lp[PW-1:0];
        mem_wd = rd_q;
        mem_wd.next = ln;
        state_next = S_UL3;
      end

      S_UL3: begin
        if (32'(ln) < 32'(PAGE_DEPTH)) begin
          mem_ra = ln[PW-1:0];
          state_next = S_UL4;
        end else begin
          state_next = ret;
        end
      end

      S_UL4: begin
        mem_we = 1'b1; mem_wa = ln[PW-1:0];
        mem_wd = rd_q;
        mem_wd.prev = lp;
        state_next = ret;
      end

      // Push a block on the front of its free list.
      S_PS0: begin
        mem_we = 1'b1; mem_wa = p_idx;
        mem_wd = '{kind: K_FREE_HEAD, order: p_ord, next: head[p_ord[OIW-1:0]],
                   prev: NIL_LINK};
        head_next[p_ord[OIW-1:0]] = 16'(p_idx);
        blk_cnt_next[p_ord[OIW-1:0]] = blk_cnt[p_ord[OIW-1:0]] + 15'd1;
        ln_next = head[p_ord[OIW-1:0]];
        if (32'(head[p_ord[OIW-1:0]]) < 32'(PAGE_DEPTH)) begin
          mem_ra = head[p_ord[OIW-1:0]][PW-1:0];
          state_next = S_PS1;
        end else begin
          state_next = ret;
        end
      end

      S_PS1: begin
        mem_we = 1'b1; mem_wa = ln[PW-1:0];
        mem_wd = rd_q;
        mem_wd.prev = 16'(p_idx);
        state_next = ret;
      end

      // Sweep every descriptor back to reserved.
      S_CLR: begin
        mem_we = 1'b1; mem_wa = clr; mem_wd = DESC_RST;
        clr_next = clr + PW'(1);
        if (clr == PW'(PAGE_DEPTH - 1)) begin
          boot_next = 1'b0;
          state_next = boot ? S_IDLE : S_QUERY;
        end
      end

      // Read the descriptor of the queried page.
      S_QUERY: begin
        mem_ra = page_ix;
        state_next = S_DONE;
      end

      // Load the result once the output register is free; keep the queried page in view.
      S_DONE: begin
        mem_ra = page_ix;
        if (!out_valid || m_tready) begin
          if (ready_flag && 32'(ordin) < 32'(ORDER_COUNT)) fblocks = blk_cnt[ordin[OIW-1:0]];
          mbit = q_ok && (rd_q.kind != K_RESERVED);
          out_valid_next = 1'b1;
          out_data_next = {3'd0, mbit, fblocks,
                           ready_flag ? pool_pages : 15'd0,
                           ready_flag ? free_pages : 15'd0,
                           res_ord, baddr, st};
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      boot <= 1'b1;
      clr <= '0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        head[i] <= NIL_LINK;
        blk_cnt[i] <= '0;
      end
      free_pages <= '0;
      pool_pages <= '0;
      ready_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      boot <= boot_next;
      clr <= clr_next;
      head <= head_next;
      blk_cnt <= blk_cnt_next;
      free_pages <= free_pages_next;
      pool_pages <= pool_pages_next;
      ready_flag <= ready_flag_next;
      out_valid <= out_valid_next;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    ret <= ret_next; act <= act_next; ordin <= ordin_next; addr <= addr_next;
    k <= k_next; idx <= idx_next; st <= st_next; res_ord <= res_ord_next;
    baddr <= baddr_next; cnt <= cnt_next; u_idx <= u_idx_next; p_idx <= p_idx_next;
    m_idx <= m_idx_next; bud <= bud_next; u_ord <= u_ord_next; p_ord <= p_ord_next;
    m_ord <= m_ord_next; ln <= ln_next; lp <= lp_next; out_data <= out_data_next;
  end

endmodule
`default_nettype wire

// File: tb/buddy_page_allocator_core_test.sv
// Self-checking testbench for the buddy page allocator core.
`default_nettype none
module buddy_page_allocator_core_test;
  import bpa_pkg::*;

  localparam int NPAGES   = PAGE_DEPTH_DEF;
  localparam int NORDERS  = ORDER_COUNT_DEF;
  localparam int PG_BYTES = PAGE_BYTES_DEF;
  localparam int STALL_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // action[2:0], block_order[6:3], byte_address[38:7], zero[39]
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // status[2:0], block_address[34:3], result_order[38:35], free_page_total[53:39],
  // managed_page_total[68:54], free_blocks_at_order[83:69], address_is_managed[84]
  logic [87:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  buddy_page_allocator_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One result item, plus an optional hand-typed status.
  typedef struct {
    status_t     st;
    logic [31:0] baddr;
    logic [3:0]  ord;
    logic [14:0] free_tot;
    logic [14:0] managed_tot;
    logic [14:0] blocks_at;
    logic        managed;
    bit          pinned;
    status_t     pin_st;
  } alloc_result_t;

  typedef struct {
    int         page;
    logic [3:0] ord;
  } live_block_t;

  typedef struct {
    action_t     act;
    logic [3:0]  ord;
    logic [31:0] addr;
    bit          pinned;
    status_t     st;
  } dir_row_t;

  alloc_result_t pending_results[$];
  live_block_t   live_blocks[$];

  // Shadow allocator state.
  kind_t       pg_kind [NPAGES];
  logic [3:0]  pg_ord  [NPAGES];
  logic [15:0] pg_next [NPAGES];
  logic [15:0] pg_prev [NPAGES];
  logic [15:0] head_of [NORDERS];
  int          blocks_of [NORDERS];
  int          free_cnt, managed_cnt;
  bit          is_ready;
  logic [31:0] base_r = REGION_BASE_RST;
  logic [14:0] span_r = SPAN_RST;

  int  errors = 0;
  int  n_items = 0, n_granted = 0, n_freed = 0, n_settings = 0;
  bit  quiet = 1'b0;
  int  idle_cycles = 0;
  int  stall_left = 0;

  function automatic int span_eff();
    return (int'(span_r) > NPAGES) ? NPAGES : int'(span_r);
  endfunction

  function automatic void wipe_state();
    for (int i = 0; i < NPAGES; i++) begin
      pg_kind[i] = K_RESERVED;
      pg_ord[i]  = '0;
      pg_next[i] = NIL_LINK;
      pg_prev[i] = NIL_LINK;
    end
    for (int i = 0; i < NORDERS; i++) begin
      head_of[i] = NIL_LINK;
      blocks_of[i] = 0;
    end
    free_cnt = 0;
    managed_cnt = 0;
    is_ready = 1'b0;
  endfunction

  // Aligned page inside the current span.
  function automatic bit page_of(input logic [31:0] a, output int idx);
    logic [31:0] off;
    idx = 0;
    if (a < base_r) return 1'b0;
    off = a - base_r;
    if (off % PG_BYTES != 0) return 1'b0;
    off = off / PG_BYTES;
    if (off >= 32'(span_eff())) return 1'b0;
    idx = int'(off);
    return 1'b1;
  endfunction

  function automatic void push_free(input int idx, input int o);
    logic [15:0] h;
    h = head_of[o];
    pg_kind[idx] = K_FREE_HEAD;
    pg_ord[idx]  = 4'(o);
    pg_prev[idx] = NIL_LINK;
    pg_next[idx] = h;
    if (int'(h) < NPAGES) pg_prev[h] = 16'(idx);
    head_of[o] = 16'(idx);
    blocks_of[o]++;
  endfunction

  function automatic void unlink_free(input int idx, input int o);
    logic [15:0] p, n;
    p = pg_prev[idx];
    n = pg_next[idx];
    if (int'(p) < NPAGES) pg_next[p] = n;
    else head_of[o] = n;
    if (int'(n) < NPAGES) pg_prev[n] = p;
    pg_next[idx] = NIL_LINK;
    pg_prev[idx] = NIL_LINK;
    if (blocks_of[o] > 0) blocks_of[o]--;
  endfunction

  // Merge a free block with free buddies of equal order, then list it.
  function automatic int coalesce(input int idx, input int o);
    int bud;
    while (o + 1 < NORDERS) begin
      bud = idx ^ (1 << o);
      if (bud >= span_eff()) break;
      if (pg_kind[bud] != K_FREE_HEAD || int'(pg_ord[bud]) != o) break;
      unlink_free(bud, o);
      if (idx < bud) begin
        pg_kind[bud] = K_FREE_TAIL;
      end else begin
        pg_kind[idx] = K_FREE_TAIL;
        idx = bud;
      end
      o++;
    end
    push_free(idx, o);
    return o;
  endfunction

  function automatic alloc_result_t predict_step(input action_t act, input logic [3:0] ord_in,
                                                 input logic [31:0] addr);
    alloc_result_t r;
    int k, idx, o;
    logic [31:0] off;
    r = '{st: ST_OK, baddr: '0, ord: '0, free_tot: '0, managed_tot: '0, blocks_at: '0,
          managed: 1'b0, pinned: 1'b0, pin_st: ST_OK};
    case (act)
      ACT_ALLOC: begin
        if (!is_ready) begin
          r.st = ST_NOT_READY;
        end else if (int'(ord_in) >= NORDERS) begin
          r.st = ST_BAD_ORDER;
        end else begin
          k = int'(ord_in);
          while (k < NORDERS && int'(head_of[k]) >= NPAGES) k++;
          if (k >= NORDERS) begin
            r.st = ST_NO_MEM;
          end else begin
            idx = int'(head_of[k]);
            unlink_free(idx, k);
            while (k > int'(ord_in)) begin
              k--;
              if (idx + (1 << k) < NPAGES) push_free(idx + (1 << k), k);
            end
            pg_kind[idx] = K_ALLOC_HEAD;
            pg_ord[idx] = ord_in;
            for (int i = 1; i < (1 << ord_in); i++)
              if (idx + i < NPAGES) pg_kind[idx + i] = K_ALLOC_TAIL;
            free_cnt = (free_cnt >= (1 << ord_in)) ? free_cnt - (1 << ord_in) : 0;
            r.baddr = base_r + 32'(idx) * 32'(PG_BYTES);
            r.ord = ord_in;
          end
        end
      end
      ACT_FREE_CHK, ACT_FREE_ANY: begin
        if (act == ACT_FREE_CHK && int'(ord_in) >= NORDERS) r.st = ST_BAD_ORDER;
        else if (!is_ready) r.st = ST_NOT_READY;
        else if (!page_of(addr, idx)) r.st = ST_BAD_ADDR;
        else if (pg_kind[idx] != K_ALLOC_HEAD) r.st = ST_NOT_HEAD;
        else if (act == ACT_FREE_CHK && pg_ord[idx] != ord_in) r.st = ST_MISMATCH;
        else begin
          o = int'(pg_ord[idx]);
          for (int i = 1; i < (1 << o); i++)
            if (idx + i < NPAGES) pg_kind[idx + i] = K_FREE_TAIL;
          free_cnt += (1 << o);
          void'(coalesce(idx, o));
          r.ord = 4'(o);
        end
      end
      ACT_RELEASE: begin
        if (!page_of(addr, idx)) r.st = ST_BAD_ADDR;
        else if (pg_kind[idx] != K_RESERVED) r.st = ST_REJECTED;
        else begin
          managed_cnt++;
          free_cnt++;
          r.ord = 4'(coalesce(idx, 0));
        end
      end
      ACT_SET_READY: is_ready = 1'b1;
      ACT_CLEAR: wipe_state();
      default: ;
    endcase
    if (is_ready && int'(ord_in) < NORDERS) r.blocks_at = 15'(blocks_of[ord_in]);
    if (is_ready && addr >= base_r) begin
      off = (addr - base_r) / PG_BYTES;
      if (off < 32'(span_eff()) && pg_kind[off] != K_RESERVED) r.managed = 1'b1;
    end
    if (is_ready) begin
      r.free_tot = 15'(free_cnt);
      r.managed_tot = 15'(managed_cnt);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one item, predict its result on acceptance and track live blocks.
  task automatic put_item(input action_t act, input logic [3:0] ord, input logic [31:0] addr,
                          input bit pinned, input status_t pin_st);
    alloc_result_t r;
    int gap, idx;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, addr, ord, act};
    do @(posedge clk); while (!s_tready);
    r = predict_step(act, ord, addr);
    r.pinned = pinned;
    r.pin_st = pin_st;
    pending_results.push_back(r);
    n_items++;
    if (act == ACT_ALLOC && r.st == ST_OK) begin
      live_blocks.push_back('{page: int'((r.baddr - base_r) / PG_BYTES), ord: ord});
      n_granted++;
    end else if ((act == ACT_FREE_CHK || act == ACT_FREE_ANY) && r.st == ST_OK) begin
      void'(page_of(addr, idx));
      foreach (live_blocks[j])
        if (live_blocks[j].page == idx) begin
          live_blocks.delete(j);
          break;
        end
      n_freed++;
    end else if (act == ACT_CLEAR) begin
      live_blocks.delete();
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_REGION_BASE) base_r = d;
    else span_r = d[14:0];
  endtask

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 1) == 0)
      return base_r + 32'(PG_BYTES) * 32'($urandom_range(0, span_eff() + 2));
    return $urandom;
  endfunction

  // One random item, weighted toward well-formed allocate and free traffic.
  task automatic random_item();
    int r, j, sp;
    logic [3:0] o;
    action_t act;
    r = $urandom_range(0, 99);
    sp = span_eff();
    if (r >= 38 && r < 68 && live_blocks.size() > 0) begin
      j = $urandom_range(0, live_blocks.size() - 1);
      o = live_blocks[j].ord;
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 7) == 0) o = 4'($urandom);
        put_item(ACT_FREE_CHK, o, base_r + 32'(live_blocks[j].page) * PG_BYTES, 0, ST_OK);
      end else begin
        put_item(ACT_FREE_ANY, 4'($urandom), base_r + 32'(live_blocks[j].page) * PG_BYTES,
                 0, ST_OK);
      end
    end else if (r < 68) begin
      o = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
      put_item(ACT_ALLOC, o, pick_addr(), 0, ST_OK);
    end else if (r < 78 && sp > 0) begin
      put_item(ACT_RELEASE, 4'($urandom), base_r + 32'($urandom_range(0, sp - 1)) * PG_BYTES,
               0, ST_OK);
    end else if (r < 88) begin
      act = action_t'($urandom_range(0, 7));
      if (act == ACT_CLEAR && $urandom_range(0, 3) != 0) act = ACT_NOP6;
      put_item(act, 4'($urandom), $urandom, 0, ST_OK);
    end else if (r < 95) begin
      act = ($urandom_range(0, 1) == 0) ? ACT_FREE_ANY : ACT_FREE_CHK;
      put_item(act, 4'($urandom), pick_addr(), 0, ST_OK);
    end else begin
      put_item(ACT_SET_READY, 4'($urandom), pick_addr(), 0, ST_OK);
    end
  endtask

  // New settings, a clean start, optional release of every page, then random traffic.
  task automatic run_phase(input logic [31:0] base, input logic [14:0] span,
                           input bit release_all, input int n_random);
    int order_q[$];
    int j, t;
    drain();
    repeat (NPAGES + 64) @(posedge clk);
    apb_write(REG_REGION_BASE, base);
    apb_write(REG_SPAN, {17'd0, span});
    n_settings++;
    put_item(ACT_CLEAR, 4'd0, 32'd0, 1, ST_OK);
    if (release_all) begin
      for (int i = 0; i < span_eff(); i++) order_q.push_back(i);
      for (int i = order_q.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order_q[i]; order_q[i] = order_q[j]; order_q[j] = t;
      end
      foreach (order_q[i])
        put_item(ACT_RELEASE, 4'($urandom), base_r + 32'(order_q[i]) * PG_BYTES, 0, ST_OK);
    end
    put_item(ACT_SET_READY, 4'd0, base_r, 1, ST_OK);
    repeat (n_random) random_item();
  endtask

  // Result checker: compares each result with the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", m_tdata[31:0], 32'd0);
      end else begin
        e = pending_results.pop_front();
        if (m_tdata[2:0] != e.st) report_mismatch("status", m_tdata[2:0], e.st);
        if (e.pinned && m_tdata[2:0] != e.pin_st)
          report_mismatch("status (directed)", m_tdata[2:0], e.pin_st);
        if (m_tdata[34:3] != e.baddr) report_mismatch("block_address", m_tdata[34:3], e.baddr);
        if (m_tdata[38:35] != e.ord) report_mismatch("result_order", m_tdata[38:35], e.ord);
        if (m_tdata[53:39] != e.free_tot)
          report_mismatch("free_page_total", m_tdata[53:39], e.free_tot);
        if (m_tdata[68:54] != e.managed_tot)
          report_mismatch("managed_page_total", m_tdata[68:54], e.managed_tot);
        if (m_tdata[83:69] != e.blocks_at)
          report_mismatch("free_blocks_at_order", m_tdata[83:69], e.blocks_at);
        if (m_tdata[84] != e.managed)
          report_mismatch("address_is_managed", m_tdata[84], e.managed);
      end
    end
  end

  // Receiver back-pressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted item or delivered result.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("buddy_page_allocator_core_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t dir_rows[26];
    dir_rows[0]  = '{ACT_ALLOC,     4'd0,  32'h0000_0000, 1, ST_NOT_READY};
    dir_rows[1]  = '{ACT_FREE_CHK,  4'd15, 32'h0000_0000, 1, ST_BAD_ORDER};
    dir_rows[2]  = '{ACT_FREE_ANY,  4'd0,  32'h0100_0000, 1, ST_NOT_READY};
    dir_rows[3]  = '{ACT_RELEASE,   4'd0,  32'h0000_0000, 1, ST_BAD_ADDR};
    dir_rows[4]  = '{ACT_RELEASE,   4'd15, 32'hFFFF_FFFF, 1, ST_BAD_ADDR};
    dir_rows[5]  = '{ACT_RELEASE,   4'd0,  32'h0100_0001, 1, ST_BAD_ADDR};
    dir_rows[6]  = '{ACT_RELEASE,   4'd0,  32'h0500_0000, 1, ST_BAD_ADDR};
    dir_rows[7]  = '{ACT_RELEASE,   4'd0,  32'h0100_0000, 1, ST_OK};
    dir_rows[8]  = '{ACT_RELEASE,   4'd0,  32'h0100_0000, 1, ST_REJECTED};
    dir_rows[9]  = '{ACT_RELEASE,   4'd1,  32'h0100_1000, 0, ST_OK};
    dir_rows[10] = '{ACT_RELEASE,   4'd0,  32'h04FF_F000, 0, ST_OK};
    dir_rows[11] = '{ACT_SET_READY, 4'd0,  32'h0100_0000, 1, ST_OK};
    dir_rows[12] = '{ACT_ALLOC,     4'd15, 32'h0100_0000, 1, ST_BAD_ORDER};
    dir_rows[13] = '{ACT_ALLOC,     4'd10, 32'h0100_0000, 1, ST_NO_MEM};
    dir_rows[14] = '{ACT_ALLOC,     4'd0,  32'h04FF_F000, 0, ST_OK};
    dir_rows[15] = '{ACT_ALLOC,     4'd0,  32'h0100_0000, 0, ST_OK};
    dir_rows[16] = '{ACT_ALLOC,     4'd0,  32'h0100_1000, 0, ST_OK};
    dir_rows[17] = '{ACT_ALLOC,     4'd0,  32'h0100_0000, 1, ST_NO_MEM};
    dir_rows[18] = '{ACT_FREE_CHK,  4'd1,  32'h0100_0000, 1, ST_MISMATCH};
    dir_rows[19] = '{ACT_FREE_ANY,  4'd0,  32'h0100_2000, 1, ST_NOT_HEAD};
    dir_rows[20] = '{ACT_FREE_CHK,  4'd0,  32'h0100_0000, 0, ST_OK};
    dir_rows[21] = '{ACT_FREE_ANY,  4'd1,  32'h0100_1000, 0, ST_OK};
    dir_rows[22] = '{ACT_NOP6,      4'd1,  32'h0100_0000, 1, ST_OK};
    dir_rows[23] = '{ACT_NOP7,      4'd0,  32'h0100_0000, 1, ST_OK};
    dir_rows[24] = '{ACT_CLEAR,     4'd0,  32'h0100_0000, 1, ST_OK};
    dir_rows[25] = '{ACT_ALLOC,     4'd0,  32'h0100_0000, 1, ST_NOT_READY};

    wipe_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset settings.
    foreach (dir_rows[i])
      put_item(dir_rows[i].act, dir_rows[i].ord, dir_rows[i].addr, dir_rows[i].pinned,
               dir_rows[i].st);

    // Random part over several settings, extremes included.
    run_phase(32'h0000_0000, 15'd32, 1, 100);
    run_phase(32'hFFFF_F000, 15'd1, 1, 40);
    run_phase($urandom & 32'hFFFF_F000, 15'd64, 1, 110);
    run_phase(32'h0040_0000, 15'd0, 0, 30);
    run_phase(32'h0040_0000, 15'h7FFF, 0, 80);
    run_phase($urandom & 32'hFFFF_F000, 15'd37, 1, 140);
    drain();
    quiet = 1'b1;
    run_phase($urandom & 32'hFFFF_F000, 15'd100, 1, 80);

    drain();
    repeat (200) @(posedge clk);
    $display("Run covered %0d items across %0d base/span settings.", n_items, n_settings + 1);
    $display("Allocations granted: %0d, blocks freed: %0d.", n_granted, n_freed);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("buddy_page_allocator_core_test passed");
    end else begin
      $display("buddy_page_allocator_core_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
